// ===== rtl/dsul_pkg.sv =====
// Package for the descending sorted unique list block.
// Holds request and status codes, field widths, defaults and the sequencer state type.
// No dependencies.
package dsul_pkg;

	// Field widths of the stream payload.
	localparam int unsigned VALUE_W = 31;
	localparam int unsigned COUNT_W = 6;
	localparam int unsigned STATUS_W = 3;

	// Default store depth and the most values one list request may emit.
	localparam int unsigned CAPACITY_DEF = 32;
	localparam int unsigned MAX_RESULTS = 32;

	// Request kinds.
	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_DELETE = 2'd1,
		REQ_CLEAR  = 2'd2,
		REQ_LIST   = 2'd3
	} req_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_DONE   = 3'd0,
		ST_MISS   = 3'd1,
		ST_FULL   = 3'd2,
		ST_LISTED = 3'd3,
		ST_EMPTY  = 3'd4
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_RESULT,
		S_LIST_RD,
		S_LIST_EMIT
	} state_t;

endpackage

// ===== rtl/descending_sorted_unique_list.sv =====
// Top level of the descending sorted unique list block.
// Uses dsul_pkg for codes, widths and the sequencer state type.
// Contains the value memory, the shared compare unit and the sequencer.

// The block keeps up to CAPACITY distinct 31-bit values, greatest first, in a
// single-port-read, single-port-write memory. It takes one request at a time
// and drops s_axis_tready until that request is finished. An insert or a
// delete walks the store through the one memory read port and one shared
// comparator, with a read state and a compare state per entry examined, then
// shifts entries with a read state and a write state per entry moved. A clear
// empties the store and goes to the result state. A list request reads each
// value and then emits it, and waits while the output register still holds
// a result not yet taken. Each result sits in an output register, so a new
// request is taken while the last result still waits for its transfer.
// There is no clearing pass after reset: the store is ready at once.
module descending_sorted_unique_list
	import dsul_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Request channel.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // item_value [30:0], list_count [36:31], zero [39:37]
	input  logic [1:0]  s_axis_tuser,  // req_type [1:0]
	// Result channel.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // out_value [30:0], zero [31]
	output logic [2:0]  m_axis_tuser,  // status [2:0]
	output logic        m_axis_tlast   // last
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned NW = (CW > COUNT_W) ? CW : COUNT_W;

	// Value store.
	logic [VALUE_W-1:0] mem [CAPACITY];
	logic [VALUE_W-1:0] rd_data_q;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      wr_addr;
	logic [VALUE_W-1:0] wr_data;
	logic               mem_we;

	// Sequencer and working registers.
	state_t             state_q, state_d;
	req_t               req_q;
	logic [VALUE_W-1:0] val_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      pos_q;
	logic [CW-1:0]      idx_q;
	logic [NW-1:0]      n_q;
	status_t            status_q;

	// Output register.
	logic               out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	status_t            out_status_q;
	logic               out_last_q;

	// Decoded request fields and handshake terms.
	req_t               in_req;
	logic [VALUE_W-1:0] in_value;
	logic [COUNT_W-1:0] in_count;
	logic               in_xfer;
	logic               out_free;
	logic               load_out;
	logic [VALUE_W-1:0] load_value;
	status_t            load_status;
	logic               load_last;

	// Shared compare unit and derived conditions.
	logic               cmp_gt;
	logic               cmp_eq;
	logic               at_end;
	logic               is_full;
	logic               list_last;
	logic [NW-1:0]      n_want;
	logic [NW-1:0]      n_cap;
	logic [NW-1:0]      n_pick;

	assign in_req   = req_t'(s_axis_tuser);
	assign in_value = s_axis_tdata[VALUE_W-1:0];
	assign in_count = s_axis_tdata[VALUE_W+COUNT_W-1:VALUE_W];

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	assign cmp_gt    = rd_data_q > val_q;
	assign cmp_eq    = rd_data_q == val_q;
	assign at_end    = pos_q == count_q;
	assign is_full   = count_q == CW'(CAPACITY);
	assign list_last = NW'(pos_q + CW'(1)) == n_q;

	// Number of values a list request emits: at least one, at most the set size
	// and the result limit.
	always_comb begin
		n_want = (in_count == '0) ? NW'(1) : NW'(in_count);
		n_cap  = (NW'(count_q) > NW'(MAX_RESULTS)) ? NW'(MAX_RESULTS) : NW'(count_q);
		n_pick = (n_want > n_cap) ? n_cap : n_want;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					unique case (in_req)
						REQ_INSERT, REQ_DELETE: state_d = S_SRCH_RD;
						REQ_CLEAR:              state_d = S_RESULT;
						REQ_LIST:               state_d = (count_q == '0) ? S_RESULT : S_LIST_RD;
						default:                state_d = S_RESULT;
					endcase
				end
			end
			S_SRCH_RD: begin
				if (!at_end) begin
					state_d = S_SRCH_CMP;
				end else if (req_q == REQ_INSERT && !is_full) begin
					state_d = S_SHIFT_RD;
				end else begin
					state_d = S_RESULT;
				end
			end
			S_SRCH_CMP: begin
				if (req_q == REQ_INSERT) begin
					if (cmp_gt) begin
						state_d = S_SRCH_RD;
					end else if (cmp_eq || is_full) begin
						state_d = S_RESULT;
					end else begin
						state_d = S_SHIFT_RD;
					end
				end else begin
					state_d = cmp_eq ? S_SHIFT_RD : S_SRCH_RD;
				end
			end
			S_SHIFT_RD: begin
				if (req_q == REQ_INSERT) begin
					state_d = (idx_q == pos_q) ? S_RESULT : S_SHIFT_WR;
				end else begin
					state_d = (idx_q + CW'(1) == count_q) ? S_RESULT : S_SHIFT_WR;
				end
			end
			S_SHIFT_WR:  state_d = S_SHIFT_RD;
			S_RESULT:    state_d = out_free ? S_IDLE : S_RESULT;
			S_LIST_RD:   state_d = S_LIST_EMIT;
			S_LIST_EMIT: begin
				if (out_free) begin
					state_d = list_last ? S_IDLE : S_LIST_RD;
				end
			end
			default:     state_d = S_IDLE;
		endcase
	end

	// Memory port control and output register load.
	always_comb begin
		rd_addr     = pos_q[AW-1:0];
		wr_addr     = idx_q[AW-1:0];
		wr_data     = rd_data_q;
		mem_we      = 1'b0;
		load_out    = 1'b0;
		load_value  = '0;
		load_status = status_q;
		load_last   = 1'b1;
		unique case (state_q)
			S_SHIFT_RD: begin
				if (req_q == REQ_INSERT) begin
					rd_addr = AW'(idx_q - CW'(1));
					if (idx_q == pos_q) begin
						mem_we  = 1'b1;
						wr_addr = pos_q[AW-1:0];
						wr_data = val_q;
					end
				end else begin
					rd_addr = AW'(idx_q + CW'(1));
				end
			end
			S_SHIFT_WR: begin
				mem_we = 1'b1;
			end
			S_RESULT: begin
				load_out = out_free;
			end
			S_LIST_EMIT: begin
				load_out    = out_free;
				load_value  = rd_data_q;
				load_status = ST_LISTED;
				load_last   = list_last;
			end
			default: begin
			end
		endcase
	end

	// Value store: one write and one registered read a cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// Sequencer state and set size.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (in_xfer && in_req == REQ_CLEAR) begin
				count_q <= '0;
			end else if (state_q == S_SHIFT_RD) begin
				if (req_q == REQ_INSERT && idx_q == pos_q) begin
					count_q <= count_q + CW'(1);
				end else if (req_q == REQ_DELETE && idx_q + CW'(1) == count_q) begin
					count_q <= count_q - CW'(1);
				end
			end
		end
	end

	// Working registers of the current request.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				req_q    <= in_req;
				val_q    <= in_value;
				n_q      <= n_pick;
				pos_q    <= '0;
				status_q <= (in_req == REQ_LIST && count_q == '0) ? ST_EMPTY : ST_DONE;
			end
			S_SRCH_RD: begin
				if (at_end) begin
					if (req_q == REQ_DELETE) begin
						status_q <= ST_MISS;
					end else if (is_full) begin
						status_q <= ST_FULL;
					end else begin
						idx_q <= count_q;
					end
				end
			end
			S_SRCH_CMP: begin
				if (req_q == REQ_INSERT) begin
					if (cmp_gt) begin
						pos_q <= pos_q + CW'(1);
					end else if (cmp_eq) begin
						status_q <= ST_MISS;
					end else if (is_full) begin
						status_q <= ST_FULL;
					end else begin
						idx_q <= count_q;
					end
				end else if (cmp_eq) begin
					idx_q <= pos_q;
				end else begin
					pos_q <= pos_q + CW'(1);
				end
			end
			S_SHIFT_WR: begin
				idx_q <= (req_q == REQ_INSERT) ? idx_q - CW'(1) : idx_q + CW'(1);
			end
			S_LIST_EMIT: begin
				if (out_free) begin
					pos_q <= pos_q + CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: holds a result until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_value_q  <= load_value;
			out_status_q <= load_status;
			out_last_q   <= load_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_value_q};
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;

endmodule
